[hw/rtl/rpsr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsr_pkg
// Types and constants shared by the receive preamble strip / realign unit.
// ----------------------------------------------------------------------------
package rpsr_pkg;

  // Frame handling mode of the back end.
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_PASS    = 3'd1,
    MODE_SCAN    = 3'd2,
    MODE_STRIP   = 3'd3,
    MODE_REALIGN = 3'd4,
    MODE_DISCARD = 3'd5
  } mode_e;

  // Status reported with each result.
  typedef enum logic [2:0] {
    ST_UNCHANGED    = 3'd0,
    ST_SFD_STRIP    = 3'd1,
    ST_REALIGN      = 3'd2,
    ST_ERROR_DROP   = 3'd3,
    ST_BAD_PREAMBLE = 3'd4
  } status_e;

  localparam logic [7:0] PREAMBLE_BYTE = 8'h55;
  localparam logic [7:0] SFD_BYTE      = 8'hd5;
  localparam logic [3:0] SFD_NIBBLE    = 4'hd;
  localparam logic [7:0] CODE_SHORT_OK = 8'd10;
  localparam logic [7:0] CODE_10M_A    = 8'd5;
  localparam logic [7:0] CODE_10M_B    = 8'd7;
  localparam int         SHORT_LEN_MAX = 64;
  localparam int         FCS_BYTES     = 4;
  localparam int         REALIGN_TRIM  = 3;

  // Register indexes (paddr[2]).
  localparam logic REG_IDX_WA   = 1'b0;
  localparam logic REG_IDX_PCHK = 1'b1;

  // Stream widths.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 4;

  typedef struct packed {
    logic wa_en;
    logic pchk_on;
  } cfg_t;

  // Classified request passed from front to back.
  typedef struct packed {
    logic       kind;
    mode_e      cls;
    logic       len_zero;
    logic       is_pre;
    logic       is_sfd;
    logic       is_nib;
    logic [7:0] data;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  typedef struct packed {
    status_e    status;
    logic [7:0] data;
    logic       valid;
    logic       last;
  } result_t;

endpackage

[hw/rtl/rpsr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsr_front
// Decodes an incoming request and classifies headers and data bytes.
// ----------------------------------------------------------------------------
module rpsr_front #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                                s_kind_i,
  input  logic [rpsr_pkg::IN_TDATA_W-1:0]     s_data_i,
  input  rpsr_pkg::cfg_t                      cfg_i,
  output rpsr_pkg::item_t                     item_o,
  output logic [LENGTH_BITS-1:0]              len_o
);
  import rpsr_pkg::*;

  logic                      rx_error;
  logic [7:0]                error_code;
  logic [15:0]               frame_length;
  logic [7:0]                data_byte;
  logic [LENGTH_BITS+15:0]   len_ext;
  logic [LENGTH_BITS-1:0]    len;
  logic                      code_10m;

  assign rx_error     = s_data_i[0];
  assign error_code   = s_data_i[8:1];
  assign frame_length = s_data_i[24:9];
  assign data_byte    = s_data_i[32:25];

  // Keep only the low LENGTH_BITS bits of the header length.
  assign len_ext  = {{LENGTH_BITS{1'b0}}, frame_length};
  assign len      = len_ext[LENGTH_BITS-1:0];
  assign code_10m = (error_code == CODE_10M_A) || (error_code == CODE_10M_B);

  always_comb begin
    item_o          = '0;
    item_o.kind     = s_kind_i;
    item_o.len_zero = (len == '0);
    item_o.is_pre   = (data_byte == PREAMBLE_BYTE);
    item_o.is_sfd   = (data_byte == SFD_BYTE);
    item_o.is_nib   = (data_byte[3:0] == SFD_NIBBLE);
    item_o.data     = data_byte;
    if (!rx_error ||
        ((error_code == CODE_SHORT_OK) && (len <= LENGTH_BITS'(SHORT_LEN_MAX)))) begin
      item_o.cls = MODE_PASS;
    end else if (cfg_i.wa_en && code_10m) begin
      item_o.cls = cfg_i.pchk_on ? MODE_PASS : MODE_SCAN;
    end else begin
      item_o.cls = MODE_DISCARD;
    end
  end

  assign len_o = len;

endmodule

[hw/rtl/rpsr_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsr_fifo
// Two-entry queue that decouples the classifying front from the back end.
// ----------------------------------------------------------------------------
module rpsr_fifo #(
  parameter int DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              full_o,
  input  logic              rd_en_i,
  output logic [DATA_W-1:0] rd_data_o,
  output logic              valid_o
);
  import rpsr_pkg::*;

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;
  logic              do_wr, do_rd;

  assign full_o    = (count_q == 2'd2);
  assign valid_o   = (count_q != 2'd0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && valid_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[hw/rtl/rpsr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsr_back
// Frame sequencer: tracks the open frame, registers any result of a request.
// ----------------------------------------------------------------------------
module rpsr_back #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  rpsr_pkg::item_t        item_i,
  input  logic [LENGTH_BITS-1:0] len_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  output rpsr_pkg::result_t      out_res_o,
  input  logic                   out_ready_i
);
  import rpsr_pkg::*;

  mode_e                  mode_q, mode_d;
  logic [LENGTH_BITS-1:0] bytes_q, bytes_d;
  logic [LENGTH_BITS-1:0] emit_q, emit_d;
  logic [7:0]             held_q, held_d;
  logic                   out_valid_q;
  result_t                res_q, res_d;
  logic                   res_load;
  logic [LENGTH_BITS-1:0] rem, emit_dec;
  mode_e                  after_mode;

  assign pop_o       = in_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  assign rem        = bytes_q - LENGTH_BITS'(1);
  assign emit_dec   = emit_q - LENGTH_BITS'(1);
  // Leftover bytes of a finished frame are swallowed.
  assign after_mode = (rem != '0) ? MODE_DISCARD : MODE_IDLE;

  always_comb begin
    mode_d   = mode_q;
    bytes_d  = bytes_q;
    emit_d   = emit_q;
    held_d   = held_q;
    res_load = 1'b0;
    res_d    = '0;
    if (pop_o) begin
      if (!item_i.kind) begin
        bytes_d = len_i;
        emit_d  = '0;
        held_d  = '0;
        if (item_i.cls == MODE_DISCARD) begin
          res_load     = 1'b1;
          res_d.status = ST_ERROR_DROP;
          res_d.last   = 1'b1;
          mode_d       = item_i.len_zero ? MODE_IDLE : MODE_DISCARD;
        end else if (item_i.len_zero) begin
          res_load     = 1'b1;
          res_d.status = (item_i.cls == MODE_PASS) ? ST_UNCHANGED : ST_BAD_PREAMBLE;
          res_d.last   = 1'b1;
          mode_d       = MODE_IDLE;
        end else begin
          mode_d = item_i.cls;
        end
      end else if ((mode_q == MODE_IDLE) || (bytes_q == '0)) begin
        mode_d = MODE_IDLE;
      end else begin
        bytes_d = rem;
        unique case (mode_q)
          MODE_PASS: begin
            res_load     = 1'b1;
            res_d.status = ST_UNCHANGED;
            res_d.data   = item_i.data;
            res_d.valid  = 1'b1;
            res_d.last   = (rem == '0);
            if (rem == '0) begin
              mode_d = MODE_IDLE;
            end
          end
          MODE_SCAN: begin
            if (item_i.is_pre && (rem != '0)) begin
              mode_d = MODE_SCAN;
            end else if (item_i.is_sfd) begin
              emit_d = (rem > LENGTH_BITS'(FCS_BYTES)) ? rem - LENGTH_BITS'(FCS_BYTES) : '0;
              if (rem <= LENGTH_BITS'(FCS_BYTES)) begin
                res_load     = 1'b1;
                res_d.status = ST_SFD_STRIP;
                res_d.last   = 1'b1;
                mode_d       = after_mode;
              end else begin
                mode_d = MODE_STRIP;
              end
            end else if (item_i.is_nib) begin
              emit_d = (rem > LENGTH_BITS'(REALIGN_TRIM)) ?
                       rem - LENGTH_BITS'(REALIGN_TRIM) : '0;
              held_d = item_i.data;
              if (rem <= LENGTH_BITS'(REALIGN_TRIM)) begin
                res_load     = 1'b1;
                res_d.status = ST_REALIGN;
                res_d.last   = 1'b1;
                mode_d       = after_mode;
              end else begin
                mode_d = MODE_REALIGN;
              end
            end else begin
              res_load     = 1'b1;
              res_d.status = ST_BAD_PREAMBLE;
              res_d.last   = 1'b1;
              mode_d       = after_mode;
            end
          end
          MODE_STRIP: begin
            emit_d       = emit_dec;
            res_load     = 1'b1;
            res_d.status = ST_SFD_STRIP;
            res_d.data   = item_i.data;
            res_d.valid  = 1'b1;
            res_d.last   = (emit_dec == '0);
            if (emit_dec == '0) begin
              mode_d = after_mode;
            end
          end
          MODE_REALIGN: begin
            // High nibble of the held byte below the low nibble of the new one.
            emit_d       = emit_dec;
            held_d       = item_i.data;
            res_load     = 1'b1;
            res_d.status = ST_REALIGN;
            res_d.data   = {item_i.data[3:0], held_q[7:4]};
            res_d.valid  = 1'b1;
            res_d.last   = (emit_dec == '0);
            if (emit_dec == '0) begin
              mode_d = after_mode;
            end
          end
          default: begin
            if (rem == '0) begin
              mode_d = MODE_IDLE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      bytes_q     <= '0;
      emit_q      <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      bytes_q <= bytes_d;
      emit_q  <= emit_d;
      held_q  <= held_d;
      if (pop_o && res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && res_load) begin
      res_q <= res_d;
    end
  end

endmodule

[hw/rtl/rx_preamble_strip_realign_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_preamble_strip_realign_unit
// Strips or repairs the preamble of received frames flagged by the MAC.
// ----------------------------------------------------------------------------
// Usage: the slave stream carries header requests (tuser = 0) and data byte
// requests (tuser = 1). A header gives the MAC error flag, error code and the
// number of data bytes that follow. The master stream returns at most one
// result per request: a status code, a byte with its valid flag, and tlast on
// the final result of a frame. The APB port holds two one-bit registers,
// workaround enable at address 0 and preamble check at address 4.
// Throughput is one request per cycle in steady state while the receiver
// keeps up. An accepted request is classified and written into the queue;
// the back end pops it and registers its result in the output register,
// from which the receiver takes it.
// The front decodes and classifies requests into a two-entry queue; the back
// sequencer follows the open frame. When the receiver stalls, the output
// register holds its result, the queue fills, and s_axis_tready falls once
// both queue entries are taken. While a result waits, the queue does not
// drain, not even for requests that yield no result.
// Reset clears the queue and the frame state and returns the registers to
// their reset values (workaround on, preamble check off). No clearing pass
// is needed after reset.
// ----------------------------------------------------------------------------
module rx_preamble_strip_realign_unit #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Slave stream, tuser: [0] kind
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: [0] rx_error, [8:1] error_code, [24:9] frame_length,
  //        [32:25] data_byte, [39:33] zero
  input  logic [rpsr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tuser,
  // Master stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: [7:0] out_byte
  output logic [rpsr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // tuser: [2:0] status, [3] byte_valid
  output logic [rpsr_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  output logic                               m_axis_tlast
);
  import rpsr_pkg::*;

  localparam int QUEUE_W = ITEM_W + LENGTH_BITS;

  cfg_t                   cfg_q;
  logic                   cfg_wr;
  item_t                  front_item, back_item;
  logic [LENGTH_BITS-1:0] front_len, back_len;
  logic                   queue_full, queue_valid, queue_pop;
  logic [QUEUE_W-1:0]     queue_rd;
  result_t                res;

  // Configuration registers; writes land on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wa_en   <= 1'b1;
      cfg_q.pchk_on <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_IDX_WA) begin
        cfg_q.wa_en <= pwdata[0];
      end else begin
        cfg_q.pchk_on <= pwdata[0];
      end
    end
  end

  assign prdata = {31'b0, (paddr[2] == REG_IDX_PCHK) ? cfg_q.pchk_on : cfg_q.wa_en};

  // Front: classify each request as it arrives.
  rpsr_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .s_kind_i (s_axis_tuser),
    .s_data_i (s_axis_tdata),
    .cfg_i    (cfg_q),
    .item_o   (front_item),
    .len_o    (front_len)
  );

  assign s_axis_tready = !queue_full;

  rpsr_fifo #(
    .DATA_W (QUEUE_W)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (s_axis_tvalid),
    .wr_data_i ({front_item, front_len}),
    .full_o    (queue_full),
    .rd_en_i   (queue_pop),
    .rd_data_o (queue_rd),
    .valid_o   (queue_valid)
  );

  assign back_item = item_t'(queue_rd[QUEUE_W-1:LENGTH_BITS]);
  assign back_len  = queue_rd[LENGTH_BITS-1:0];

  // Back: frame sequencing and the output register.
  rpsr_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (queue_valid),
    .item_i      (back_item),
    .len_i       (back_len),
    .pop_o       (queue_pop),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = res.data;
  assign m_axis_tuser = {res.valid, res.status};
  assign m_axis_tlast = res.last;

endmodule

[hw/rtl/rpsr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsr_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rpsr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rpsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [rpsr_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  input logic                             m_axis_tlast
);
  import rpsr_pkg::*;

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // A result without a delivered byte carries a zero byte and closes a frame.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[3] |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("byteless result is not a frame end");

  // Drops never deliver a byte.
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser[2:0] == ST_ERROR_DROP) ||
                      (m_axis_tuser[2:0] == ST_BAD_PREAMBLE)) |-> !m_axis_tuser[3])
    else $error("dropped frame delivered a byte");

  // Status codes stay within the defined set.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[2:0] <= ST_BAD_PREAMBLE))
    else $error("undefined status code");

endmodule

bind rx_preamble_strip_realign_unit rpsr_checker u_rpsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[verif/rx_preamble_strip_realign_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_preamble_strip_realign_unit_test
// Self-checking stream testbench for the receive preamble strip / realign unit.
// ----------------------------------------------------------------------------
// Header and data byte requests go in on the slave stream. A frame-level
// predictor runs each accepted request and queues the result it should
// cause. Every result taken from the master stream is matched against the
// oldest queued result. A short directed table opens the run. Eight random
// phases follow, each with a register setting and a mix of sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module rx_preamble_strip_realign_unit_test;
  import rpsr_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int LIMIT_CYCLES  = 200000;
  // Covers the output register and the two-entry front queue, with margin.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_REQS   = 550;
  localparam int PHASES        = 8;
  localparam int MAX_REPORTS   = 10;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // Register settings per phase: the workaround bit and the preamble check
  // bit go through all four combinations.
  localparam logic [3:0] WA_PLAN   = 4'b1010;
  localparam logic [3:0] PCHK_PLAN = 4'b0110;

  // One request on the slave stream, the way the block sees it.
  typedef struct packed {
    logic       kind;
    logic       rx_err;
    logic [7:0] code;
    logic [15:0] length;
    logic [7:0] data;
  } req_t;

  // One line of the directed table. Where typed is set, want is the result
  // the line must give, written by hand.
  typedef struct {
    req_t    req;
    logic    typed;
    result_t want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic        m_axis_tlast;

  // Frame state of the predictor, plus its copy of the two registers.
  mode_e       fr_mode  = MODE_IDLE;
  logic [15:0] fr_left  = '0;
  logic [15:0] out_left = '0;
  logic [7:0]  held     = '0;
  logic        cfg_wa   = 1'b1;
  logic        cfg_pchk = 1'b0;

  result_t  pending_results[$];
  req_t     burst[$];
  dir_row_t directed_rows[$];

  int cycle_count;
  int bad_results;
  int results_seen;
  int useful_reqs;
  int headers_sent;
  int gap_pct;
  int stall_pct;
  int hold_ticket;

  rx_preamble_strip_realign_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // A frame that ran out of output: whatever bytes the header still promised
  // are swallowed, otherwise the unit goes back to waiting for a header.
  function automatic void close_frame();
    fr_mode = (fr_left != 0) ? MODE_DISCARD : MODE_IDLE;
  endfunction

  // Advances the frame state by one request. Returns 1 and fills res when
  // the request causes a result.
  function automatic logic strip_realign_step(input req_t r, output result_t res);
    logic [15:0] rem;
    logic [7:0]  b;
    mode_e       nxt;
    res = '0;
    res.status = ST_UNCHANGED;
    if (r.kind == KIND_HEADER) begin
      // A header always restarts the frame state, even in mid-frame.
      fr_left  = r.length;
      out_left = '0;
      held     = '0;
      if (!r.rx_err || (r.code == CODE_SHORT_OK && r.length <= SHORT_LEN_MAX)) begin
        nxt = MODE_PASS;
      end else if (cfg_wa && (r.code == CODE_10M_A || r.code == CODE_10M_B)) begin
        nxt = cfg_pchk ? MODE_PASS : MODE_SCAN;
      end else begin
        nxt = MODE_DISCARD;
      end
      if (nxt == MODE_DISCARD) begin
        res.status = ST_ERROR_DROP;
        res.last   = 1'b1;
        close_frame();
        return 1'b1;
      end
      if (r.length == 0) begin
        // An empty frame in scan has nothing to decide on.
        fr_mode    = MODE_IDLE;
        res.status = (nxt == MODE_PASS) ? ST_UNCHANGED : ST_BAD_PREAMBLE;
        res.last   = 1'b1;
        return 1'b1;
      end
      fr_mode = nxt;
      return 1'b0;
    end

    if (fr_mode == MODE_IDLE || fr_left == 0) begin
      fr_mode = MODE_IDLE;
      return 1'b0;
    end
    fr_left = fr_left - 1'b1;
    rem     = fr_left;
    b       = r.data;
    case (fr_mode)
      MODE_PASS: begin
        res.data  = b;
        res.valid = 1'b1;
        res.last  = (rem == 0);
        if (rem == 0) fr_mode = MODE_IDLE;
        return 1'b1;
      end
      MODE_SCAN: begin
        if (b == PREAMBLE_BYTE && rem != 0) return 1'b0;
        if (b == SFD_BYTE) begin
          out_left = (rem > FCS_BYTES) ? 16'(rem - FCS_BYTES) : 16'd0;
          if (out_left == 0) begin
            res.status = ST_SFD_STRIP;
            res.last   = 1'b1;
            close_frame();
            return 1'b1;
          end
          fr_mode = MODE_STRIP;
          return 1'b0;
        end
        if (b[3:0] == SFD_NIBBLE) begin
          out_left = (rem > REALIGN_TRIM) ? 16'(rem - REALIGN_TRIM) : 16'd0;
          held     = b;
          if (out_left == 0) begin
            res.status = ST_REALIGN;
            res.last   = 1'b1;
            close_frame();
            return 1'b1;
          end
          fr_mode = MODE_REALIGN;
          return 1'b0;
        end
        res.status = ST_BAD_PREAMBLE;
        res.last   = 1'b1;
        close_frame();
        return 1'b1;
      end
      MODE_STRIP: begin
        out_left   = out_left - 1'b1;
        res.status = ST_SFD_STRIP;
        res.data   = b;
        res.valid  = 1'b1;
        res.last   = (out_left == 0);
        if (out_left == 0) close_frame();
        return 1'b1;
      end
      MODE_REALIGN: begin
        // High nibble of the held byte goes low, low nibble of the new byte
        // goes high.
        res.data   = {b[3:0], held[7:4]};
        held       = b;
        out_left   = out_left - 1'b1;
        res.status = ST_REALIGN;
        res.valid  = 1'b1;
        res.last   = (out_left == 0);
        if (out_left == 0) close_frame();
        return 1'b1;
      end
      default: begin
        if (rem == 0) fr_mode = MODE_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic dir_row_t hdr(input logic err, input logic [7:0] code,
                                   input logic [15:0] len);
    dir_row_t d;
    d.req        = '0;
    d.req.kind   = KIND_HEADER;
    d.req.rx_err = err;
    d.req.code   = code;
    d.req.length = len;
    d.typed      = 1'b0;
    d.want       = '0;
    return d;
  endfunction

  function automatic dir_row_t dat(input logic [7:0] b);
    dir_row_t d;
    d.req      = '0;
    d.req.kind = KIND_DATA;
    d.req.data = b;
    d.typed    = 1'b0;
    d.want     = '0;
    return d;
  endfunction

  function automatic dir_row_t with_result(input dir_row_t d, input status_e st,
                                           input logic [7:0] b, input logic v,
                                           input logic l);
    d.typed       = 1'b1;
    d.want.status = st;
    d.want.data   = b;
    d.want.valid  = v;
    d.want.last   = l;
    return d;
  endfunction

  function automatic void report(input string what, input result_t want,
                                 input result_t got);
    if (bad_results < MAX_REPORTS) begin
      $display("[%0t] %s: expected status %0d byte %02h valid %0b last %0b,",
               $time, what, want.status, want.data, want.valid, want.last);
      $display("    got status %0d byte %02h valid %0b last %0b",
               got.status, got.data, got.valid, got.last);
    end
    bad_results++;
  endfunction

  // Offers one request, waits for it to be taken and queues what it should
  // cause. Called at a rising edge, returns at the edge that took it.
  task automatic send_req(input req_t r, input logic typed, input result_t want);
    result_t res;
    logic    has;
    logic    ignored;
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {7'd0, r.data, r.length, r.code, r.rx_err};
    do @(posedge clk_i); while (!s_axis_tready);
    ignored = (r.kind == KIND_DATA) && (fr_mode == MODE_IDLE || fr_left == 0);
    has = strip_realign_step(r, res);
    if (typed) res = want;
    if (has || typed) pending_results.push_back(res);
    if (!ignored) useful_reqs++;
    if (r.kind == KIND_HEADER) headers_sent++;
  endtask

  // Register write: setup phase, then access phase; psel drops after the
  // access so that back-to-back writes never drive psel twice in one step.
  task automatic apb_write(input logic idx, input logic val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {31'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_IDX_WA) cfg_wa = val;
    else cfg_pchk = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Requests that cause no result can still sit in the front queue when the
  // last expected result has come out, so the wait runs on for a settling time.
  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Builds one frame, or a short run of noise, into the burst queue. Most
  // frames are well formed; a few claim a length that does not match the
  // bytes that follow, which leaves frames cut short by the next header or
  // trailing bytes with no frame open.
  task automatic make_frame();
    req_t       r;
    logic [7:0] body[$];
    logic [3:0] hi;
    int         pick;
    int         n;
    pick = $urandom_range(99);
    if (pick >= 88) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        r.kind   = 1'($urandom_range(1));
        r.rx_err = 1'($urandom_range(1));
        r.code   = 8'($urandom_range(255));
        r.length = 16'($urandom_range(65535));
        r.data   = 8'($urandom_range(255));
        burst.push_back(r);
      end
      return;
    end
    r        = '0;
    r.kind   = KIND_HEADER;
    r.rx_err = 1'b1;
    if (pick < 25) begin
      r.rx_err = 1'b0;
      r.code   = 8'($urandom_range(255));
      n = $urandom_range(0, 8);
      repeat (n) body.push_back(8'($urandom_range(255)));
    end else if (pick < 65) begin
      // 10 Mbps style frame: a run of preamble bytes, the deciding byte,
      // then payload and whatever stands for the FCS.
      r.code = $urandom_range(1) ? CODE_10M_A : CODE_10M_B;
      n = $urandom_range(0, 7);
      repeat (n) body.push_back(PREAMBLE_BYTE);
      case ($urandom_range(3))
        0, 1: body.push_back(SFD_BYTE);
        2: begin
          hi = 4'($urandom_range(15));
          body.push_back({hi, SFD_NIBBLE});
        end
        default: body.push_back(8'($urandom_range(255)));
      endcase
      n = $urandom_range(0, 9);
      repeat (n) body.push_back(8'($urandom_range(255)));
    end else if (pick < 75) begin
      r.code = CODE_SHORT_OK;
      n = $urandom_range(0, 6);
      repeat (n) body.push_back(8'($urandom_range(255)));
    end else begin
      r.code = 8'($urandom_range(255));
      n = $urandom_range(0, 5);
      repeat (n) body.push_back(8'($urandom_range(255)));
    end
    r.length = 16'(body.size());
    if (pick >= 65 && pick < 75 && $urandom_range(1)) begin
      // Short-frame code around the length bound; the bytes are cut short.
      r.length = 16'($urandom_range(SHORT_LEN_MAX - 4, SHORT_LEN_MAX + 4));
    end else if ($urandom_range(9) == 0) begin
      r.length = 16'($urandom_range(body.size() + 3));
    end
    burst.push_back(r);
    foreach (body[i]) begin
      r      = '0;
      r.kind = KIND_DATA;
      r.data = body[i];
      burst.push_back(r);
    end
  endtask

  // Receiver. It stalls at the rate set for the phase, and holds off for a
  // long stretch whenever the sequence asks for it, so the unit fills up and
  // drops s_axis_tready.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Each result taken from the master stream is matched against the oldest
  // queued result, field by field.
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = status_e'(m_axis_tuser[2:0]);
      got.valid  = m_axis_tuser[3];
      got.data   = m_axis_tdata;
      got.last   = m_axis_tlast;
      results_seen++;
      if (pending_results.size() == 0) begin
        report("result with nothing pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status || got.data != want.data ||
            got.valid != want.valid || got.last != want.last) begin
          report("result mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results still pending.",
               cycle_count, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : sequencer
    dir_row_t d;
    int       c;
    int       target;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    gap_pct     = 0;
    stall_pct   = 0;
    hold_ticket = 0;

    // Directed table, run with the registers at their reset values
    // (workaround on, preamble check off).
    // A data byte with no frame open is ignored.
    directed_rows.push_back(dat(8'hff));
    // Empty frame that is kept.
    directed_rows.push_back(with_result(hdr(1'b0, 8'h00, 16'd0),
                                        ST_UNCHANGED, 8'h00, 1'b0, 1'b1));
    // Clean frame passes byte for byte.
    directed_rows.push_back(hdr(1'b0, 8'hff, 16'd2));
    directed_rows.push_back(with_result(dat(8'h00), ST_UNCHANGED, 8'h00, 1'b1, 1'b0));
    directed_rows.push_back(with_result(dat(8'hff), ST_UNCHANGED, 8'hff, 1'b1, 1'b1));
    // Other error code drops the frame; its byte is swallowed.
    directed_rows.push_back(with_result(hdr(1'b1, 8'd3, 16'd1),
                                        ST_ERROR_DROP, 8'h00, 1'b0, 1'b1));
    directed_rows.push_back(dat(8'hab));
    // Empty frame in scan.
    directed_rows.push_back(with_result(hdr(1'b1, CODE_10M_A, 16'd0),
                                        ST_BAD_PREAMBLE, 8'h00, 1'b0, 1'b1));
    // SFD strip with one byte out, then an FCS byte dropped.
    directed_rows.push_back(hdr(1'b1, CODE_10M_B, 16'd8));
    directed_rows.push_back(dat(PREAMBLE_BYTE));
    directed_rows.push_back(dat(PREAMBLE_BYTE));
    directed_rows.push_back(dat(SFD_BYTE));
    directed_rows.push_back(dat(8'h3c));
    directed_rows.push_back(dat(8'h00));
    // Header in mid-frame abandons the rest; nibble realign with one output.
    directed_rows.push_back(hdr(1'b1, CODE_10M_A, 16'd6));
    directed_rows.push_back(dat(PREAMBLE_BYTE));
    directed_rows.push_back(dat(8'h5d));
    directed_rows.push_back(dat(8'h1f));
    // Nothing left after the strip.
    directed_rows.push_back(hdr(1'b1, CODE_10M_B, 16'd3));
    directed_rows.push_back(dat(SFD_BYTE));
    // A preamble byte that is also the last byte decides as a bad preamble.
    directed_rows.push_back(hdr(1'b1, CODE_10M_A, 16'd1));
    directed_rows.push_back(dat(PREAMBLE_BYTE));
    // Short-frame code right at the bound passes, one past it drops.
    directed_rows.push_back(hdr(1'b1, CODE_SHORT_OK, 16'd64));
    directed_rows.push_back(with_result(hdr(1'b1, CODE_SHORT_OK, 16'd65),
                                        ST_ERROR_DROP, 8'h00, 1'b0, 1'b1));
    // Field extremes.
    directed_rows.push_back(with_result(hdr(1'b1, 8'hff, 16'hffff),
                                        ST_ERROR_DROP, 8'h00, 1'b0, 1'b1));
    directed_rows.push_back(hdr(1'b0, 8'h00, 16'hffff));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      d = directed_rows[i];
      send_req(d.req, d.typed, d.want);
    end
    s_axis_tvalid <= 1'b0;

    // Random phases. Registers are only written once the unit has drained.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      c = (p + p / 4) % 4;
      apb_write(REG_IDX_WA, WA_PLAN[c]);
      apb_write(REG_IDX_PCHK, PCHK_PLAN[c]);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 53; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 53; end
        default: begin gap_pct = 35; stall_pct = 35; end
      endcase
      // With the sender going flat out, a long receiver hold-off backs the
      // unit up all the way to its input.
      if (gap_pct == 0 && stall_pct == 0) hold_ticket++;
      target = useful_reqs + RANDOM_REQS / PHASES;
      while (useful_reqs < target) begin
        make_frame();
        while (burst.size() != 0) send_req(burst.pop_front(), 1'b0, '0);
      end
      s_axis_tvalid <= 1'b0;
    end

    wait_idle();
    $display("Run covered %0d requests with %0d headers over %0d register and flow settings,",
             useful_reqs, headers_sent, PHASES);
    $display("and compared %0d results against the frame predictor (%0d wrong).",
             results_seen, bad_results);
    if (bad_results == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[rx_preamble_strip_realign_unit.f]
hw/rtl/rpsr_pkg.sv
hw/rtl/rpsr_front.sv
hw/rtl/rpsr_fifo.sv
hw/rtl/rpsr_back.sv
hw/rtl/rx_preamble_strip_realign_unit.sv
hw/rtl/rpsr_checker.sv
verif/rx_preamble_strip_realign_unit_test.sv
